/* rtl/plst_pkg.sv */
package plst_pkg;

  // Operation codes carried in the request opcode field
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_ERASE  = 3'd1;
  localparam logic [2:0] OP_GET    = 3'd2;
  localparam logic [2:0] OP_INDEX  = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // What every cell of the chain does in a given cycle
  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_INSERT,
    MODE_ERASE,
    MODE_ROTATE
  } cell_mode_t;

  // Request payload
  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  position;
    logic [31:0] value;
  } in_t;

  // Response payload
  typedef struct packed {
    logic        ok;
    logic [31:0] read_value;
    logic [3:0]  found_index;
    logic [4:0]  entry_count;
    logic        is_full;
  } out_t;

endpackage

/* rtl/plst_cell.sv */
// One list slot. Takes its next word from itself, from the broadcast word,
// or from the left or right neighbor, depending on the chain mode and on
// where this slot sits relative to the broadcast position.
module plst_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IW         = 4,
  parameter int IDX        = 0
) (
  input  logic                   clk,
  input  plst_pkg::cell_mode_t   mode,
  input  logic [IW-1:0]          pos,
  input  logic [DATA_WIDTH-1:0]  word,
  input  logic [DATA_WIDTH-1:0]  left_data,
  input  logic [DATA_WIDTH-1:0]  right_data,
  output logic [DATA_WIDTH-1:0]  data
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  // Slot update: insert opens a gap at pos, erase closes it, rotate walks
  // the whole ring one place toward slot zero
  always_comb begin
    data_nxt = data_r;
    unique case (mode)
      plst_pkg::MODE_INSERT: begin
        if (MY_IDX == pos) begin
          data_nxt = word;
        end else if (MY_IDX > pos) begin
          data_nxt = left_data;
        end
      end
      plst_pkg::MODE_ERASE: begin
        if (MY_IDX >= pos) begin
          data_nxt = right_data;
        end
      end
      plst_pkg::MODE_ROTATE: data_nxt = right_data;
      default:               data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

/* rtl/plst_seq.sv */
// Request sequencer: holds the entry count, decodes each request into a
// chain mode, runs the full-ring scan for get and index-of while watching
// slot zero, and keeps the response register.
module plst_seq #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  plst_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output plst_pkg::out_t                      out_data,
  output plst_pkg::cell_mode_t                mode,
  output logic [$clog2(CAPACITY)-1:0]         pos,
  output logic [DATA_WIDTH-1:0]               word,
  input  logic [DATA_WIDTH-1:0]               head
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;
  localparam logic [CMPW-1:0] CAP_C   = CMPW'(CAPACITY);
  localparam logic [IW-1:0]   LAST_ST = IW'(CAPACITY - 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [IW-1:0]         step_r, step_nxt;
  logic [2:0]            op_r, op_nxt;
  logic [3:0]            qpos_r, qpos_nxt;
  logic [DATA_WIDTH-1:0] word_r, word_nxt;
  logic                  found_r, found_nxt;
  logic [3:0]            idx_r, idx_nxt;
  logic [DATA_WIDTH-1:0] rd_r, rd_nxt;
  logic                  out_valid_r, out_valid_nxt;
  plst_pkg::out_t        out_r, out_nxt;

  logic                  out_free;
  logic                  accept;
  logic                  step_en;
  logic [CMPW-1:0]       in_pos_ext;
  logic [CMPW-1:0]       qpos_ext;
  logic [CMPW-1:0]       count_ext;
  logic [CMPW-1:0]       step_ext;
  logic [CMPW-1:0]       pos_eff;
  logic [CMPW-1:0]       count_new_ext;
  logic                  ins_ok;
  logic                  get_ok;

  // Handshake: take a request only when idle and the response slot frees up
  assign out_free = !out_valid_r || !out_stall;
  assign accept   = in_valid && (state_r == ST_IDLE) && out_free;
  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign step_en  = (step_r != LAST_ST) || out_free;

  // Comparisons run at a common width
  assign in_pos_ext = CMPW'(in_data.position);
  assign qpos_ext   = CMPW'(qpos_r);
  assign count_ext  = CMPW'(count_r);
  assign step_ext   = CMPW'(step_r);
  assign pos_eff    = (in_pos_ext < count_ext) ? in_pos_ext : count_ext;
  assign ins_ok     = (count_ext < CAP_C) && (in_pos_ext < CAP_C);
  assign get_ok     = qpos_ext < count_ext;

  // Broadcast to the cells
  assign pos  = pos_eff[IW-1:0];
  assign word = DATA_WIDTH'(in_data.value);

  assign count_new_ext = CMPW'(count_nxt);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    op_nxt        = op_r;
    qpos_nxt      = qpos_r;
    word_nxt      = word_r;
    found_nxt     = found_r;
    idx_nxt       = idx_r;
    rd_nxt        = rd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    mode          = plst_pkg::MODE_HOLD;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_nxt.ok          = 1'b0;
          out_nxt.read_value  = '0;
          out_nxt.found_index = '0;
          out_valid_nxt       = 1'b1;
          unique case (in_data.opcode)
            plst_pkg::OP_INSERT: begin
              if (ins_ok) begin
                mode       = plst_pkg::MODE_INSERT;
                count_nxt  = count_r + 1'b1;
                out_nxt.ok = 1'b1;
              end
            end
            plst_pkg::OP_ERASE: begin
              if (in_pos_ext < count_ext) begin
                mode       = plst_pkg::MODE_ERASE;
                count_nxt  = count_r - 1'b1;
                out_nxt.ok = 1'b1;
              end
            end
            plst_pkg::OP_GET, plst_pkg::OP_INDEX: begin
              // response comes at the end of the ring scan
              out_valid_nxt = 1'b0;
              state_nxt     = ST_SCAN;
              step_nxt      = '0;
              op_nxt        = in_data.opcode;
              qpos_nxt      = in_data.position;
              word_nxt      = DATA_WIDTH'(in_data.value);
              found_nxt     = 1'b0;
              idx_nxt       = '0;
              rd_nxt        = '0;
            end
            plst_pkg::OP_CLEAR: begin
              count_nxt  = '0;
              out_nxt.ok = 1'b1;
            end
            default: out_nxt.ok = 1'b0;
          endcase
          out_nxt.entry_count = count_new_ext[4:0];
          out_nxt.is_full     = (count_new_ext == CAP_C);
        end
      end
      ST_SCAN: begin
        if (step_en) begin
          // slot zero holds entry step_r; the ring advances one place
          mode     = plst_pkg::MODE_ROTATE;
          step_nxt = step_r + 1'b1;
          if ((op_r == plst_pkg::OP_INDEX) && !found_r && (step_ext < count_ext) &&
              (head == word_r)) begin
            found_nxt = 1'b1;
            idx_nxt   = step_ext[3:0];
          end
          if ((op_r == plst_pkg::OP_GET) && get_ok && (step_ext == qpos_ext)) begin
            rd_nxt = head;
          end
          if (step_r == LAST_ST) begin
            state_nxt           = ST_IDLE;
            out_valid_nxt       = 1'b1;
            out_nxt.ok          = (op_r == plst_pkg::OP_GET) ? get_ok : found_nxt;
            out_nxt.read_value  = 32'(rd_nxt);
            out_nxt.found_index = idx_nxt;
            out_nxt.entry_count = count_ext[4:0];
            out_nxt.is_full     = (count_ext == CAP_C);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    step_r  <= step_nxt;
    op_r    <= op_nxt;
    qpos_r  <= qpos_nxt;
    word_r  <= word_nxt;
    found_r <= found_nxt;
    idx_r   <= idx_nxt;
    rd_r    <= rd_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/positional_list_store_top.sv */
// Ordered list of up to CAPACITY words kept in a ring of slot cells. Insert,
// erase, clear and unused opcodes finish in the cycle the request is taken,
// so they can be taken every cycle while responses drain; insert and erase
// move every slot from the request position onward toward or away from its
// neighbor. For get and index-of the ring rotates once all the way round,
// slot zero is compared against the request each step, and the list is back
// in place at the end. That full rotation sets the latency of both lookups,
// and no new request is taken during it. One response per request, in order,
// through a registered output stage.
module positional_list_store_top #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  plst_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output plst_pkg::out_t  out_data
);

  localparam int IW = $clog2(CAPACITY);

  plst_pkg::cell_mode_t  mode;
  logic [IW-1:0]         pos;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] slot [CAPACITY];

  // Sequencer and response register
  plst_seq #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mode      (mode),
    .pos       (pos),
    .word      (word),
    .head      (slot[0])
  );

  // Ring of slots; the last slot's right neighbor is slot zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    plst_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IW         (IW),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .mode       (mode),
      .pos        (pos),
      .word       (word),
      .left_data  (slot[(i == 0) ? 0 : i - 1]),
      .right_data (slot[(i == CAPACITY - 1) ? 0 : i + 1]),
      .data       (slot[i])
    );
  end

endmodule
